@@ sv/counting_trie_dictionary_macros.svh @@
// ---------------------------------------------------------------------------
// Counting trie dictionary assertion macros
// Concurrent assertion wrappers shared by the RTL modules.
// ---------------------------------------------------------------------------
`ifndef COUNTING_TRIE_DICTIONARY_MACROS_SVH
`define COUNTING_TRIE_DICTIONARY_MACROS_SVH

`ifndef NO_ASSERTIONS
// check on every clock edge outside reset
`define CTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check in the cycle after the antecedent
`define CTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);
`else
`define CTD_ASSERT(lbl, prop, msg)
`define CTD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/ctd_pkg.sv @@
// ---------------------------------------------------------------------------
// Counting trie dictionary package
// Sizes, codes, item types and controller/datapath interface types.
// ---------------------------------------------------------------------------
package ctd_pkg;

  localparam int NODE_COUNT    = 1024;
  localparam int ALPHABET_SIZE = 256;
  localparam int COUNT_BITS    = 16;

  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int USED_W     = NODE_W + 1;
  localparam int SYM_W      = $clog2(ALPHABET_SIZE);
  localparam int ADDR_W     = NODE_W + SYM_W;
  localparam int FUNC_W     = 2;
  localparam int SYMBOL_W   = 8;
  localparam int OUT_CNT_W  = 16;
  localparam int SYMBOL_NUM = 2 ** SYMBOL_W;

  typedef enum logic [FUNC_W-1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2
  } op_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [SYMBOL_W-1:0] symbol;
    logic                has_symbol;
    logic                last;
  } item_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] count;
    logic                 status;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_COUNT
  } ctl_state_e;

  typedef struct packed {
    logic clear;
    logic accept;
    logic walk;
    logic count;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic item_walk;
    logic item_last;
    logic key_last;
  } sts_t;

  typedef logic [SYM_W-1:0] sym_map_t [SYMBOL_NUM];

  function automatic sym_map_t build_sym_map();
    sym_map_t m;
    for (int i = 0; i < SYMBOL_NUM; i++) begin
      m[i] = SYM_W'(i % ALPHABET_SIZE);
    end
    return m;
  endfunction

  localparam sym_map_t SYM_MAP = build_sym_map();

endpackage

@@ sv/ctd_ctrl.sv @@
// ---------------------------------------------------------------------------
// Counting trie dictionary controller
// Sequences the clearing pass, item acceptance, child walk and count update.
// ---------------------------------------------------------------------------
`include "counting_trie_dictionary_macros.svh"

module ctd_ctrl
  import ctd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          if (sts_i.item_walk) begin
            state_d = ST_WALK;
          end else if (sts_i.item_last) begin
            state_d = ST_COUNT;
          end
        end
      end
      ST_WALK: begin
        state_d = sts_i.key_last ? ST_COUNT : ST_IDLE;
      end
      ST_COUNT: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear = 1'b1;
      ST_IDLE: begin
        busy_o       = 1'b0;
        cmd_o.accept = start_i;
      end
      ST_WALK:  cmd_o.walk  = 1'b1;
      ST_COUNT: cmd_o.count = 1'b1;
      default:  cmd_o       = '0;
    endcase
  end

  `CTD_ASSERT(a_walk_after_accept, cmd_o.walk |-> $past(cmd_o.accept), "walk without item")
  `CTD_ASSERT_NEXT(a_count_single, cmd_o.count, !cmd_o.count, "count step repeated")
  `CTD_ASSERT(a_accept_idle, cmd_o.accept |-> (state_q == ST_IDLE), "item taken outside idle")

endmodule

@@ sv/ctd_datapath.sv @@
// ---------------------------------------------------------------------------
// Counting trie dictionary datapath
// Child table, end count store, node pool and key walk registers.
// ---------------------------------------------------------------------------
`include "counting_trie_dictionary_macros.svh"

module ctd_datapath
  import ctd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  input  item_t   item_i,
  output sts_t    sts_o,
  output result_t result_o,
  output logic    strobe_o
);

  logic [NODE_W-1:0]     child_mem [2**ADDR_W];
  logic [COUNT_BITS-1:0] cnt_mem   [NODE_COUNT];

  logic [NODE_W-1:0]     cur_q, cur_d, cur_eff;
  logic                  in_key_q, in_key_d;
  logic [FUNC_W-1:0]     op_q, op_d;
  logic                  lost_q, lost_d, lost_eff;
  logic [USED_W-1:0]     used_q, used_d;
  logic [ADDR_W-1:0]     clr_q;
  logic                  fresh_q, fresh_d;
  logic                  strobe_q;
  logic                  last_q;
  logic [ADDR_W-1:0]     slot_q, slot_d;
  logic [NODE_W-1:0]     child_rd_q;
  logic [COUNT_BITS-1:0] cnt_rd_q;
  result_t               result_q, result_d;

  logic                  alloc;
  logic                  child_we;
  logic [ADDR_W-1:0]     child_wa;
  logic [NODE_W-1:0]     child_wd;
  logic                  cnt_we;
  logic [NODE_W-1:0]     cnt_wa;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic [COUNT_BITS-1:0] cnt_old, cnt_new;
  logic                  cnt_upd;

  assign cur_eff  = in_key_q ? cur_q : '0;
  assign lost_eff = in_key_q & lost_q;
  assign slot_d   = {cur_eff, SYM_MAP[item_i.symbol]};

  assign sts_o.clear_done = (clr_q == '1);
  assign sts_o.item_walk  = item_i.has_symbol & ~lost_eff;
  assign sts_o.item_last  = item_i.last;
  assign sts_o.key_last   = last_q;

  always_comb begin
    cur_d    = cur_q;
    in_key_d = in_key_q;
    op_d     = op_q;
    lost_d   = lost_q;
    used_d   = used_q;
    fresh_d  = fresh_q;
    alloc    = 1'b0;
    if (cmd_i.accept) begin
      in_key_d = ~item_i.last;
      fresh_d  = 1'b0;
      cur_d    = cur_eff;
      if (!in_key_q) begin
        op_d   = item_i.func;
        lost_d = 1'b0;
      end
    end
    if (cmd_i.walk) begin
      if (child_rd_q != '0) begin
        cur_d = child_rd_q;
      end else if (op_q == OP_INSERT && used_q < USED_W'(NODE_COUNT)) begin
        alloc   = 1'b1;
        cur_d   = used_q[NODE_W-1:0];
        used_d  = used_q + 1'b1;
        fresh_d = 1'b1;
      end else begin
        lost_d = 1'b1;
      end
    end
  end

  always_comb begin
    cnt_old = fresh_q ? '0 : cnt_rd_q;
    cnt_new = cnt_old;
    if (op_q == OP_INSERT) begin
      if (cnt_old != '1) cnt_new = cnt_old + 1'b1;
    end else if (op_q == OP_ERASE) begin
      if (cnt_old != '0) cnt_new = cnt_old - 1'b1;
    end
    cnt_upd = cmd_i.count & ~lost_q & (op_q == OP_INSERT || op_q == OP_ERASE);
    if (lost_q) begin
      result_d.count  = '0;
      result_d.status = (op_q == OP_INSERT) ? STATUS_FULL : STATUS_OK;
    end else begin
      result_d.count  = OUT_CNT_W'(cnt_new);
      result_d.status = STATUS_OK;
    end
  end

  always_comb begin
    child_we = cmd_i.clear | alloc;
    child_wa = cmd_i.clear ? clr_q : slot_q;
    child_wd = cmd_i.clear ? '0 : used_q[NODE_W-1:0];
    cnt_we   = (cmd_i.clear & (clr_q < ADDR_W'(NODE_COUNT))) | alloc | cnt_upd;
    if (cmd_i.clear) begin
      cnt_wa = clr_q[NODE_W-1:0];
      cnt_wd = '0;
    end else if (alloc) begin
      cnt_wa = used_q[NODE_W-1:0];
      cnt_wd = '0;
    end else begin
      cnt_wa = cur_q;
      cnt_wd = cnt_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (child_we) child_mem[child_wa] <= child_wd;
    if (cmd_i.accept) child_rd_q <= child_mem[slot_d];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cmd_i.accept | cmd_i.walk) cnt_rd_q <= cnt_mem[cur_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      in_key_q <= 1'b0;
      op_q     <= '0;
      lost_q   <= 1'b0;
      used_q   <= USED_W'(1);
      clr_q    <= '0;
      fresh_q  <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      cur_q    <= cur_d;
      in_key_q <= in_key_d;
      op_q     <= op_d;
      lost_q   <= lost_d;
      used_q   <= used_d;
      fresh_q  <= fresh_d;
      strobe_q <= cmd_i.count;
      if (cmd_i.clear) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      last_q <= item_i.last;
      slot_q <= slot_d;
    end
    if (cmd_i.count) result_q <= result_d;
  end

  assign result_o = result_q;
  assign strobe_o = strobe_q;

  `CTD_ASSERT(a_used_range, (used_q != '0) && (used_q <= USED_W'(NODE_COUNT)), "pool count out of range")
  `CTD_ASSERT(a_cur_allocated, {1'b0, cur_q} < used_q, "walk node not allocated")
  `CTD_ASSERT_NEXT(a_alloc_step, alloc, used_q == USED_W'($past(used_q) + 1'b1), "pool count slip")
  `CTD_ASSERT(a_full_on_insert, (strobe_o && result_o.status) |-> (op_q == OP_INSERT), "full status off insert")

endmodule

@@ sv/counting_trie_dictionary.sv @@
// ---------------------------------------------------------------------------
// Counting trie dictionary
// Character-serial trie with per-key multiplicity counts and a node pool.
// ---------------------------------------------------------------------------
// Keys arrive one character per item; the first item of a key sets the
// operation (search, insert, erase) and one result appears on the strobe,
// one cycle wide, after the item marked last. The result cannot be held off,
// so capture it when the strobe is high. After reset the block sweeps the
// whole child table and count store, one entry per cycle, and holds busy
// high meanwhile. An item that walks nowhere (no symbol, or a key whose path
// is already lost) is only accepted; an item that walks is accepted with a
// registered child table read, followed by the walk or node allocation; the
// last item of a key adds a step for the count read-modify-write.
// ---------------------------------------------------------------------------
module counting_trie_dictionary
  import ctd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    strobe_o,
  output result_t result_o
);

  cmd_t cmd;
  sts_t sts;

  ctd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  ctd_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .sts_o    (sts),
    .result_o (result_o),
    .strobe_o (strobe_o)
  );

endmodule
